// File: src/sfdp_pkg.sv
// shared types and constants for the sfdp basic table decoder
`default_nettype none
package sfdp_pkg;

	localparam int NUM_LANES = 4;
	localparam int NUM_SLOTS = 4;

	// erase size exponents for the four known erase sizes
	localparam logic [7:0] EXP_4K   = 8'd12;
	localparam logic [7:0] EXP_32K  = 8'd15;
	localparam logic [7:0] EXP_64K  = 8'd16;
	localparam logic [7:0] EXP_256K = 8'd18;

	// slot indexes into the erase opcode set
	localparam int SLOT_SMALL = 0;
	localparam int SLOT_MID   = 1;
	localparam int SLOT_LARGE = 2;
	localparam int SLOT_HUGE  = 3;

	localparam logic [18:0] BLK_4K   = 19'd4096;
	localparam logic [18:0] BLK_32K  = 19'd32768;
	localparam logic [18:0] BLK_64K  = 19'd65536;
	localparam logic [18:0] BLK_256K = 19'd262144;

	localparam logic [31:0] FOUR_BYTE_LIMIT = 32'd16777216;
	localparam logic [1:0]  ADDR_MODE_4B_ONLY = 2'b10;
	localparam logic [1:0]  ERASE_4K_SUPPORTED = 2'b01;
	localparam logic [2:0]  ADDR_3B = 3'd3;
	localparam logic [2:0]  ADDR_4B = 3'd4;
	localparam logic [7:0]  REV_MAJOR_ONE = 8'd1;
	localparam logic [7:0]  REV_MINOR_PAGE = 8'd5;
	localparam logic [15:0] WBUF_64 = 16'd64;
	localparam logic [15:0] WBUF_1  = 16'd1;
	localparam logic [30:0] EXP_MIN = 31'd3;
	localparam logic [30:0] EXP_MAX = 31'd34;

	typedef struct packed {
		logic [31:0] dword_one;
		logic [31:0] dword_two;
		logic [31:0] dword_eight;
		logic [31:0] dword_nine;
		logic [31:0] dword_eleven;
		logic [7:0]  rev_major;
		logic [7:0]  rev_minor;
	} sfdp_in_t;

	typedef struct packed {
		logic [31:0] capacity_bytes;
		logic        capacity_clipped;
		logic [2:0]  address_bytes;
		logic [7:0]  erase_small_opcode;
		logic [7:0]  erase_mid_opcode;
		logic [7:0]  erase_large_opcode;
		logic [7:0]  erase_huge_opcode;
		logic [18:0] block_size;
		logic [15:0] page_bytes;
	} sfdp_out_t;

	// what one erase-type lane found: which size slot it targets and its opcode
	typedef struct packed {
		logic [NUM_SLOTS-1:0] hit;
		logic [7:0]           opcode;
	} lane_t;

	// capacity, address length and page size
	typedef struct packed {
		logic [31:0] capacity;
		logic        clipped;
		logic [2:0]  addr_bytes;
		logic [15:0] wg;
	} geom_t;

endpackage
`default_nettype wire

// File: src/sfdp_erase_lane.sv
// one erase-type entry: size exponent to slot select
`default_nettype none
module sfdp_erase_lane
	import sfdp_pkg::*;
(
	input  wire logic [15:0] entry,
	output lane_t            result
);

	always_comb begin
		result.hit = '0;
		result.opcode = entry[15:8];
		case (entry[7:0])
			EXP_4K:   result.hit[SLOT_SMALL] = 1'b1;
			EXP_32K:  result.hit[SLOT_MID]   = 1'b1;
			EXP_64K:  result.hit[SLOT_LARGE] = 1'b1;
			EXP_256K: result.hit[SLOT_HUGE]  = 1'b1;
			default:  result.hit = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: src/sfdp_geom_decode.sv
// capacity, address length and page size decode
`default_nettype none
module sfdp_geom_decode
	import sfdp_pkg::*;
(
	input  wire sfdp_in_t din,
	output geom_t         geom
);

	logic [30:0] n;
	logic [4:0]  shamt;

	assign n = din.dword_two[30:0];
	assign shamt = 5'(n - EXP_MIN);

	always_comb begin
		geom.clipped = 1'b0;
		if (din.dword_two[31]) begin
			if (n < EXP_MIN) begin
				geom.capacity = '0;
				geom.clipped = 1'b1;
			end else if (n > EXP_MAX) begin
				geom.capacity = '1;
				geom.clipped = 1'b1;
			end else begin
				geom.capacity = 32'd1 << shamt;
			end
		end else begin
			// bit 31 clear, so the increment cannot wrap
			geom.capacity = ({1'b0, din.dword_two[30:0]} + 32'd1) >> 3;
		end

		if (geom.capacity <= FOUR_BYTE_LIMIT && din.dword_one[18:17] != ADDR_MODE_4B_ONLY)
			geom.addr_bytes = ADDR_3B;
		else
			geom.addr_bytes = ADDR_4B;

		if (din.rev_major == REV_MAJOR_ONE && din.rev_minor < REV_MINOR_PAGE)
			geom.wg = din.dword_one[2] ? WBUF_64 : WBUF_1;
		else if (din.rev_major == REV_MAJOR_ONE)
			geom.wg = 16'd1 << din.dword_eleven[7:4];
		else
			geom.wg = '0;
	end

endmodule
`default_nettype wire

// File: src/sfdp_merge.sv
// combines the erase lanes in table order and picks the block size
`default_nettype none
module sfdp_merge
	import sfdp_pkg::*;
(
	input  wire logic [7:0] small_op,
	input  wire lane_t      lanes [NUM_LANES],
	output logic [7:0]      ops [NUM_SLOTS],
	output logic [18:0]     block_size
);

	always_comb begin
		for (int s = 0; s < NUM_SLOTS; s++) begin
			ops[s] = '0;
		end
		ops[SLOT_SMALL] = small_op;
		// later lanes override earlier ones, even with a zero opcode
		for (int l = 0; l < NUM_LANES; l++) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (lanes[l].hit[s])
					ops[s] = lanes[l].opcode;
			end
		end

		if (ops[SLOT_SMALL] != '0)
			block_size = BLK_4K;
		else if (ops[SLOT_MID] != '0)
			block_size = BLK_32K;
		else if (ops[SLOT_LARGE] != '0)
			block_size = BLK_64K;
		else if (ops[SLOT_HUGE] != '0)
			block_size = BLK_256K;
		else
			block_size = '0;
	end

endmodule
`default_nettype wire

// File: src/sfdp_flash_parameter_decoder.sv
// top level: sfdp basic parameter table decoder, two-stage pipeline
//
//  channel | direction | payload     | handshake
//  --------+-----------+-------------+---------------------
//  in      | input     | sfdp_in_t   | in_valid / in_stall
//  out     | output    | sfdp_out_t  | out_valid / out_stall
//
// one beat in gives one beat out, through the stage-one and output registers
// a new beat is taken every cycle while in_stall is low; the two pipeline registers set the latency
// arst_n clears both valid flags; payload registers are not reset
// out_stall holds the output register and backs up through stage one,
// in_stall rises only when both stages hold a beat and the output is stalled
`default_nettype none
module sfdp_flash_parameter_decoder
	import sfdp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire sfdp_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output sfdp_out_t      out_data
);

	// stage one: parallel decode of the four erase-type entries plus geometry
	lane_t      lane_res [NUM_LANES];
	logic [15:0] entries [NUM_LANES];
	geom_t      geom;

	assign entries[0] = in_data.dword_eight[15:0];
	assign entries[1] = in_data.dword_eight[31:16];
	assign entries[2] = in_data.dword_nine[15:0];
	assign entries[3] = in_data.dword_nine[31:16];

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		sfdp_erase_lane u_lane (
			.entry  (entries[g]),
			.result (lane_res[g])
		);
	end

	sfdp_geom_decode u_geom (
		.din  (in_data),
		.geom (geom)
	);

	// handshake: each stage moves when the one after it can take a beat
	logic adv_s2;
	logic adv_s1;
	logic valid_s1;

	assign adv_s2 = !out_valid || !out_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	lane_t      lanes_s1 [NUM_LANES];
	geom_t      geom_s1;
	logic [7:0] small_op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			lanes_s1 <= lane_res;
			geom_s1 <= geom;
			// dword 1 names the 4 KiB opcode only when 4 KiB erase is supported
			small_op_s1 <= (in_data.dword_one[1:0] == ERASE_4K_SUPPORTED) ?
				in_data.dword_one[15:8] : 8'd0;
		end
	end

	// stage two: merge lanes in table order, then the output register
	logic [7:0]  ops [NUM_SLOTS];
	logic [18:0] blk;

	sfdp_merge u_merge (
		.small_op   (small_op_s1),
		.lanes      (lanes_s1),
		.ops        (ops),
		.block_size (blk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			out_data.capacity_bytes     <= geom_s1.capacity;
			out_data.capacity_clipped   <= geom_s1.clipped;
			out_data.address_bytes      <= geom_s1.addr_bytes;
			out_data.erase_small_opcode <= ops[SLOT_SMALL];
			out_data.erase_mid_opcode   <= ops[SLOT_MID];
			out_data.erase_large_opcode <= ops[SLOT_LARGE];
			out_data.erase_huge_opcode  <= ops[SLOT_HUGE];
			out_data.block_size         <= blk;
			out_data.page_bytes         <= geom_s1.wg;
		end
	end

endmodule
`default_nettype wire

// File: sim/sfdp_settings_check.sv
// checker for the sfdp decoder: predicts flash settings per table beat and compares results
`timescale 1ns / 1ps
`default_nettype none
module sfdp_settings_check
	import sfdp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_stall,
	input  wire sfdp_in_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_stall,
	input  wire sfdp_out_t out_data,
	output int             fail_count,
	output int             pending,
	output int             settings_checked
);

	sfdp_out_t settings_due[$];
	int        fails = 0;
	int        due_count = 0;
	int        checked = 0;

	assign fail_count       = fails;
	assign pending          = due_count;
	assign settings_checked = checked;

	function automatic sfdp_out_t predict_flash_settings(input sfdp_in_t t);
		sfdp_out_t   r;
		logic [7:0]  ops [NUM_SLOTS];
		logic [63:0] entries;
		logic [30:0] n;
		logic [7:0]  size_exp;
		logic [7:0]  op;
		int          k;
		r = '0;
		if (t.dword_two[31]) begin
			n = t.dword_two[30:0];
			if (n < EXP_MIN) begin
				r.capacity_bytes   = '0;
				r.capacity_clipped = 1'b1;
			end else if (n > EXP_MAX) begin
				r.capacity_bytes   = '1;
				r.capacity_clipped = 1'b1;
			end else begin
				r.capacity_bytes = 32'd1 << (n - EXP_MIN);
			end
		end else begin
			// linear form holds bits minus one
			r.capacity_bytes = (t.dword_two + 32'd1) >> 3;
		end
		if (r.capacity_bytes <= FOUR_BYTE_LIMIT && t.dword_one[18:17] != ADDR_MODE_4B_ONLY)
			r.address_bytes = ADDR_3B;
		else
			r.address_bytes = ADDR_4B;
		for (k = 0; k < NUM_SLOTS; k++)
			ops[k] = 8'h00;
		if (t.dword_one[1:0] == ERASE_4K_SUPPORTED)
			ops[SLOT_SMALL] = t.dword_one[15:8];
		// erase types 1..4 in order, later ones overwrite
		entries = {t.dword_nine, t.dword_eight};
		for (k = 0; k < NUM_LANES; k++) begin
			size_exp = entries[16*k +: 8];
			op       = entries[16*k+8 +: 8];
			case (size_exp)
				EXP_4K:   ops[SLOT_SMALL] = op;
				EXP_32K:  ops[SLOT_MID]   = op;
				EXP_64K:  ops[SLOT_LARGE] = op;
				EXP_256K: ops[SLOT_HUGE]  = op;
				default:  ;
			endcase
		end
		r.erase_small_opcode = ops[SLOT_SMALL];
		r.erase_mid_opcode   = ops[SLOT_MID];
		r.erase_large_opcode = ops[SLOT_LARGE];
		r.erase_huge_opcode  = ops[SLOT_HUGE];
		if (ops[SLOT_SMALL] != 8'h00)
			r.block_size = BLK_4K;
		else if (ops[SLOT_MID] != 8'h00)
			r.block_size = BLK_32K;
		else if (ops[SLOT_LARGE] != 8'h00)
			r.block_size = BLK_64K;
		else if (ops[SLOT_HUGE] != 8'h00)
			r.block_size = BLK_256K;
		else
			r.block_size = '0;
		if (t.rev_major == REV_MAJOR_ONE && t.rev_minor < REV_MINOR_PAGE)
			r.page_bytes = t.dword_one[2] ? WBUF_64 : WBUF_1;
		else if (t.rev_major == REV_MAJOR_ONE)
			r.page_bytes = 16'd1 << t.dword_eleven[7:4];
		else
			r.page_bytes = '0;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			report_mismatch($sformatf("%s expected %h got %h", name, want, got));
	endtask

	always @(posedge clk) begin
		sfdp_out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (settings_due.size() == 0) begin
					report_mismatch($sformatf("result beat with no table pending: %h",
						out_data));
				end else begin
					want = settings_due.pop_front();
					check_field("capacity_bytes", want.capacity_bytes, out_data.capacity_bytes);
					check_field("capacity_clipped", 32'(want.capacity_clipped),
						32'(out_data.capacity_clipped));
					check_field("address_bytes", 32'(want.address_bytes),
						32'(out_data.address_bytes));
					check_field("erase_small_opcode", 32'(want.erase_small_opcode),
						32'(out_data.erase_small_opcode));
					check_field("erase_mid_opcode", 32'(want.erase_mid_opcode),
						32'(out_data.erase_mid_opcode));
					check_field("erase_large_opcode", 32'(want.erase_large_opcode),
						32'(out_data.erase_large_opcode));
					check_field("erase_huge_opcode", 32'(want.erase_huge_opcode),
						32'(out_data.erase_huge_opcode));
					check_field("block_size", 32'(want.block_size), 32'(out_data.block_size));
					check_field("page_bytes", 32'(want.page_bytes),
						32'(out_data.page_bytes));
					checked++;
				end
			end
			if (in_valid && !in_stall)
				settings_due.push_back(predict_flash_settings(in_data));
			due_count <= settings_due.size();
		end
	end

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// testbench top for the sfdp decoder: clock, reset, table stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import sfdp_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	sfdp_in_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	sfdp_out_t out_data;

	int fail_count;
	int pending;
	int settings_checked;
	int tables_sent = 0;
	int directed_sent = 0;
	int dens_exp [8] = '{0, 1, 2, 3, 27, 28, 34, 35};

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sfdp_flash_parameter_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// prediction and comparison live in the checker, the top only drives
	sfdp_settings_check settings_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_data         (out_data),
		.fail_count       (fail_count),
		.pending          (pending),
		.settings_checked (settings_checked)
	);

	function automatic sfdp_in_t make_table(input logic [31:0] d1, input logic [31:0] d2,
			input logic [31:0] d8, input logic [31:0] d9, input logic [31:0] d11,
			input logic [7:0] major, input logic [7:0] minor);
		sfdp_in_t t;
		t.dword_one    = d1;
		t.dword_two    = d2;
		t.dword_eight  = d8;
		t.dword_nine   = d9;
		t.dword_eleven = d11;
		t.rev_major    = major;
		t.rev_minor    = minor;
		return t;
	endfunction

	// two erase-type entries packed as one dword: size exponent then opcode, twice
	function automatic logic [31:0] erase_pair(input logic [7:0] e0, input logic [7:0] o0,
			input logic [7:0] e1, input logic [7:0] o1);
		return {o1, e1, o0, e0};
	endfunction

	// erase entry for random tables: mostly a known size, sometimes junk
	function automatic logic [15:0] random_erase_entry();
		logic [7:0] size_exp;
		logic [7:0] op;
		case ($urandom_range(0, 4))
			0: size_exp = EXP_4K;
			1: size_exp = EXP_32K;
			2: size_exp = EXP_64K;
			3: size_exp = EXP_256K;
			default: size_exp = 8'($urandom);
		endcase
		// a zero opcode now and then exercises the override-to-nothing path
		op = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom);
		return {op, size_exp};
	endfunction

	// well-formed table with random content, or pure noise
	function automatic sfdp_in_t random_table();
		sfdp_in_t t;
		t = make_table($urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom),
			8'($urandom));
		if ($urandom_range(0, 99) < 15)
			return t;
		if ($urandom_range(0, 2) != 0)
			t.dword_one[1:0] = ERASE_4K_SUPPORTED;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: t.dword_two = {1'b1, 31'($urandom_range(0, 40))};
			5:             t.dword_two[31] = 1'b1;
			6, 7:          t.dword_two = {1'b0, 31'($urandom_range(0, 32'h0fff_ffff))};
			default:       t.dword_two[31] = 1'b0;
		endcase
		t.dword_eight = {random_erase_entry(), random_erase_entry()};
		t.dword_nine  = {random_erase_entry(), random_erase_entry()};
		if ($urandom_range(0, 3) != 0)
			t.rev_major = REV_MAJOR_ONE;
		if ($urandom_range(0, 4) < 3)
			t.rev_minor = 8'($urandom_range(0, 8));
		return t;
	endfunction

	// idle length between beats: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// present one beat and hold it until the decoder takes it
	task automatic send_table(input sfdp_in_t t);
		in_data  <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		tables_sent++;
	endtask

	// drop valid for a while; zero means the next beat follows back to back
	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// receiver side: quiet stretches, choppy stretches and the odd long hold
	initial begin
		@(posedge clk);
		forever begin
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
			repeat ($urandom_range(5, 40)) begin
				out_stall <= ($urandom_range(0, 2) == 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("** sfdp_flash_parameter_decoder: FAILED **");
		$finish;
	end

	initial begin
		bit burst;
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all-zero and all-one tables
		send_table(make_table('0, '0, '0, '0, '0, 8'h00, 8'h00));
		idle_sender(pick_gap());
		send_table(make_table('1, '1, '1, '1, '1, 8'hff, 8'hff));
		idle_sender(pick_gap());

		// exponent density: both clip sides, smallest legal, the 16 MiB edge, largest legal
		foreach (dens_exp[k]) begin
			send_table(make_table(32'h0000_2001, {1'b1, 31'(dens_exp[k])},
				erase_pair(EXP_32K, 8'h52, EXP_64K, 8'hd8), '0, 32'h80, REV_MAJOR_ONE, 8'd6));
			idle_sender(pick_gap());
		end

		// linear density: exactly 16 MiB, just above, and the largest value
		send_table(make_table(32'h0000_2001, 32'h07ff_ffff, '0, '0, '0, REV_MAJOR_ONE, 8'd0));
		idle_sender(pick_gap());
		send_table(make_table(32'h0000_2001, 32'h0800_0007, '0, '0, '0, REV_MAJOR_ONE, 8'd0));
		idle_sender(pick_gap());
		send_table(make_table(32'h0000_2001, 32'h7fff_ffff, '0, '0, '0, REV_MAJOR_ONE, 8'd0));
		idle_sender(pick_gap());

		// small part that only supports 4-byte addressing
		send_table(make_table(32'h0004_2001, {1'b1, 31'd20}, '0, '0, '0, REV_MAJOR_ONE, 8'd0));
		idle_sender(pick_gap());

		// type 1 wipes the 4 KiB opcode from dword 1 with a zero opcode
		send_table(make_table(32'h0000_2001, {1'b1, 31'd24},
			erase_pair(EXP_4K, 8'h00, EXP_32K, 8'h52), '0, '0, REV_MAJOR_ONE, 8'd0));
		idle_sender(pick_gap());

		// unknown size exponents only, no erase at all; rev 1.4 with write buffer
		send_table(make_table(32'h0000_0004, {1'b1, 31'd24},
			erase_pair(8'd13, 8'h11, 8'd17, 8'h22), erase_pair(8'd0, 8'h33, 8'hff, 8'h44),
			'0, REV_MAJOR_ONE, 8'd4));
		idle_sender(pick_gap());

		// 64 KiB given three times, the last one wins
		send_table(make_table('0, {1'b1, 31'd24}, erase_pair(EXP_64K, 8'hd8, EXP_64K, 8'hdc),
			erase_pair(EXP_256K, 8'hdd, EXP_64K, 8'h21), '0, REV_MAJOR_ONE, 8'd0));
		idle_sender(pick_gap());

		// only the 256 KiB size, then only 64 KiB
		send_table(make_table('0, {1'b1, 31'd30}, '0, erase_pair(8'd0, 8'h00, EXP_256K, 8'hdc),
			'0, REV_MAJOR_ONE, 8'd5));
		idle_sender(pick_gap());
		send_table(make_table('0, {1'b1, 31'd30}, erase_pair(EXP_64K, 8'hd8, 8'd0, 8'h00), '0,
			'0, REV_MAJOR_ONE, 8'd5));
		idle_sender(pick_gap());

		// 4 KiB flagged in dword 1 but with a zero opcode
		send_table(make_table(32'h0000_0001, {1'b1, 31'd24}, '0, '0, '0, REV_MAJOR_ONE, 8'd0));
		idle_sender(pick_gap());

		// revision paths: old without buffer, page exponents 0 and 15, other majors
		send_table(make_table('0, '0, '0, '0, '0, REV_MAJOR_ONE, 8'd0));
		idle_sender(pick_gap());
		send_table(make_table('0, '0, '0, '0, 32'h0000_0000, REV_MAJOR_ONE, 8'd5));
		idle_sender(pick_gap());
		send_table(make_table('0, '0, '0, '0, 32'h0000_00f0, REV_MAJOR_ONE, 8'hff));
		idle_sender(pick_gap());
		send_table(make_table(32'h0000_0004, '0, '0, '0, 32'h0000_0080, 8'd2, 8'd0));
		idle_sender(pick_gap());
		send_table(make_table(32'h0000_0004, '0, '0, '0, 32'h0000_0080, 8'd0, 8'd3));
		directed_sent = tables_sent;

		// random part; bursts with no idling come and go
		burst = 1'b0;
		for (i = 0; i < 1200; i++) begin
			if (i % 100 == 0)
				burst = ($urandom_range(0, 2) == 0);
			if (i == 600) begin
				// hold off until the pipeline has fully drained
				in_valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end else if (!burst) begin
				idle_sender(pick_gap());
			end
			send_table(random_table());
		end
		in_valid <= 1'b0;

		// drain, then keep clocking for any stray result beat
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);

		$display("%0d table beats driven (%0d directed), %0d result beats checked",
			tables_sent, directed_sent, settings_checked);
		$display("covered exponent and linear density, both clip sides, 3/4-byte addressing,");
		$display("erase overrides and unknown sizes, and every revision path");
		if (fail_count == 0)
			$display("** sfdp_flash_parameter_decoder: PASSED **");
		else
			$display("** sfdp_flash_parameter_decoder: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
